/* rtl/aapr_pkg.sv */
package aapr_pkg;

	// Field widths
	localparam int COORD_WIDTH = 32;
	localparam int AXIS_WIDTH  = 16;
	localparam int COS_WIDTH   = 16;
	localparam int Q14_WIDTH   = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = (AXIS_WIDTH > COS_WIDTH) ? AXIS_WIDTH : COS_WIDTH;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_X = 2'd0,
		REG_AXIS_Y = 2'd1,
		REG_AXIS_Z = 2'd2,
		REG_COS    = 2'd3
	} cfg_reg_t;

	// Q2.14 constants
	localparam int Q14_ONE = 16384;

	// Matrix builder arithmetic
	localparam int NORM_MSB = 22;              // axis is scaled until its top magnitude bit is here
	localparam int AX_W     = NORM_MSB + 3;    // signed width of the scaled axis
	localparam int MOP_W    = 34;              // shared multiplier operand width
	localparam int MPR_W    = 2 * MOP_W;       // shared multiplier product width
	localparam int MR_W     = 36;              // Q30 intermediate width

	// Rotation datapath
	localparam int PROD_W = COORD_WIDTH + Q14_WIDTH;
	localparam int SUM_W  = PROD_W + 2;

	typedef logic signed [Q14_WIDTH-1:0] q14_t;
	typedef q14_t [8:0] mat_t;

	typedef struct packed {
		logic en1;
		logic en2;
	} pipe_ctl_t;

	typedef enum logic [2:0] {
		GEN_IDLE,
		GEN_INIT,
		GEN_SQ,
		GEN_SQRT_L,
		GEN_DIV,
		GEN_SQRT_S,
		GEN_MUL,
		GEN_ASM
	} gen_state_t;

endpackage

/* rtl/aapr_isqrt.sv */
module aapr_isqrt import aapr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;

	// two radicand bits per step, one root bit out
	assign rem_sh = {rem_q[33:0], rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

/* rtl/aapr_div.sv */
module aapr_div import aapr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);

	// Quotient must fit in 32 bits: dividend[63:32] < divisor.
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] dvs_q;
	logic [31:0] quo_q;
	logic [32:0] r_sh;
	logic [32:0] r_sub;
	logic        ge;

	assign r_sh  = {rem_q, lo_q[31]};
	assign r_sub = r_sh - {1'b0, dvs_q};
	assign ge    = (r_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			lo_q  <= dividend[31:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r_sub[31:0] : r_sh[31:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/aapr_mgen.sv */
module aapr_mgen import aapr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  busy,
	output mat_t                  matrix
);

	// configuration and matrix
	logic signed [AXIS_WIDTH-1:0] axis_q [3];
	logic signed [COS_WIDTH-1:0]  cos_q;
	logic                         start_q;
	mat_t                         mat_q;

	// sequencer
	gen_state_t state_q, state_d;
	logic [3:0] idx_q;
	logic       ph_q;
	logic       go_q;

	// datapath
	logic signed [AX_W-1:0]      ax_q [3];
	logic signed [COS_WIDTH-1:0] c14_q;
	logic [47:0]                 n2_q;
	logic [28:0]                 csq_q;
	logic [31:0]                 len_q;
	logic [31:0]                 s_q;
	logic signed [MOP_W-1:0]     u_q [3];
	logic signed [MR_W-1:0]      pp_q [6];
	logic signed [MR_W-1:0]      su_q [3];
	logic signed [MPR_W-1:0]     prod_q;

	// setup logic
	logic [AXIS_WIDTH-1:0]       amag [3];
	logic [AXIS_WIDTH-1:0]       mx;
	logic [4:0]                  msb_pos;
	logic [4:0]                  sh;
	logic                        axis_zero;
	logic signed [COS_WIDTH-1:0] c14;
	logic signed [AX_W-1:0]      ax_sh [3];

	// unit hookup
	logic                    sq_start, sq_busy;
	logic [63:0]             sq_rad;
	logic [31:0]             sq_root;
	logic                    dv_start, dv_busy;
	logic [63:0]             dv_dividend;
	logic [31:0]             dv_quo;
	logic signed [AX_W-1:0]  dv_ax;
	logic [AX_W-1:0]         dv_mag;
	logic signed [MOP_W-1:0] dv_qx;
	logic signed [MOP_W-1:0] op_a, op_b;
	logic signed [MOP_W-1:0] k_op;
	logic signed [MR_W-1:0]  c_q30;
	logic signed [MR_W-1:0]  m30;
	logic [2:0]              pidx;
	logic [28:0]             s_diff;

	function automatic q14_t to_q14(input logic signed [MR_W:0] e);
		logic signed [MR_W:0] r;
		r = (e + (MR_W+1)'(32768)) >>> 16;
		if (r > (MR_W+1)'(32767))
			return q14_t'(16'sh7fff);
		else if (r < -(MR_W+1)'(32768))
			return q14_t'(16'sh8000);
		else
			return q14_t'(r);
	endfunction

	function automatic logic signed [MR_W:0] add2(input logic signed [MR_W-1:0] a,
	                                              input logic signed [MR_W-1:0] b);
		return (MR_W+1)'(a) + (MR_W+1)'(b);
	endfunction

	function automatic logic signed [MR_W:0] sub2(input logic signed [MR_W-1:0] a,
	                                              input logic signed [MR_W-1:0] b);
		return (MR_W+1)'(a) - (MR_W+1)'(b);
	endfunction

	// axis scaling: bring the largest magnitude up to bit NORM_MSB
	always_comb begin
		for (int i = 0; i < 3; i++)
			amag[i] = axis_q[i][AXIS_WIDTH-1] ? (~axis_q[i] + 1'b1) : axis_q[i];
		mx = amag[0];
		if (amag[1] > mx) mx = amag[1];
		if (amag[2] > mx) mx = amag[2];
		msb_pos = '0;
		for (int i = 0; i < AXIS_WIDTH; i++)
			if (mx[i]) msb_pos = 5'(i);
		sh = 5'(NORM_MSB) - msb_pos;
		axis_zero = (mx == '0);
		for (int i = 0; i < 3; i++)
			ax_sh[i] = AX_W'(axis_q[i]) <<< sh;
		if (cos_q > COS_WIDTH'(Q14_ONE))
			c14 = COS_WIDTH'(Q14_ONE);
		else if (cos_q < -COS_WIDTH'(Q14_ONE))
			c14 = -COS_WIDTH'(Q14_ONE);
		else
			c14 = cos_q;
	end

	assign k_op   = (MOP_W'(1) <<< 30) - (MOP_W'(c14_q) <<< 16);
	assign c_q30  = MR_W'(c14_q) <<< 16;
	assign m30    = MR_W'(prod_q >>> 30);
	assign pidx   = 3'(idx_q - 4'd9);
	assign s_diff = 29'(1 << 28) - csq_q;

	always_comb begin
		unique case (idx_q[1:0])
			2'd1:    dv_ax = ax_q[1];
			2'd2:    dv_ax = ax_q[2];
			default: dv_ax = ax_q[0];
		endcase
		dv_mag      = dv_ax[AX_W-1] ? AX_W'(-dv_ax) : AX_W'(dv_ax);
		dv_dividend = (64'(dv_mag) << 37) + 64'(len_q >> 1);
		dv_qx       = signed'(MOP_W'(dv_quo));
	end

	// register writes; any write rebuilds the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= '0;
			cos_q     <= COS_WIDTH'(Q14_ONE);
			start_q   <= 1'b0;
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_AXIS_X: axis_q[0] <= cfg_wdata[AXIS_WIDTH-1:0];
					REG_AXIS_Y: axis_q[1] <= cfg_wdata[AXIS_WIDTH-1:0];
					REG_AXIS_Z: axis_q[2] <= cfg_wdata[AXIS_WIDTH-1:0];
					REG_COS:    cos_q     <= cfg_wdata[COS_WIDTH-1:0];
				endcase
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		priority if (start_q) begin
			state_d = GEN_INIT;
		end else begin
			unique case (state_q)
				GEN_IDLE:   state_d = GEN_IDLE;
				GEN_INIT:   state_d = axis_zero ? GEN_IDLE : GEN_SQ;
				GEN_SQ:     if (ph_q && idx_q == 4'd3) state_d = GEN_SQRT_L;
				GEN_SQRT_L: if (go_q && !sq_busy) state_d = GEN_DIV;
				GEN_DIV:    if (go_q && !dv_busy && idx_q == 4'd2) state_d = GEN_SQRT_S;
				GEN_SQRT_S: if (go_q && !sq_busy) state_d = GEN_MUL;
				GEN_MUL:    if (ph_q && idx_q == 4'd14) state_d = GEN_ASM;
				GEN_ASM:    state_d = GEN_IDLE;
				default:    state_d = GEN_IDLE;
			endcase
		end
	end

	// outputs: unit launches and multiplier operands
	always_comb begin
		busy     = (state_q != GEN_IDLE) || start_q;
		sq_start = ((state_q == GEN_SQRT_L) || (state_q == GEN_SQRT_S)) && !go_q && !start_q;
		dv_start = (state_q == GEN_DIV) && !go_q && !start_q;
		sq_rad   = (state_q == GEN_SQRT_S) ? {3'b000, s_diff, 32'h0} : {2'b00, n2_q, 14'h0};
		op_a     = '0;
		op_b     = '0;
		if (state_q == GEN_SQ) begin
			unique case (idx_q)
				4'd0: begin op_a = MOP_W'(ax_q[0]); op_b = MOP_W'(ax_q[0]); end
				4'd1: begin op_a = MOP_W'(ax_q[1]); op_b = MOP_W'(ax_q[1]); end
				4'd2: begin op_a = MOP_W'(ax_q[2]); op_b = MOP_W'(ax_q[2]); end
				default: begin op_a = MOP_W'(c14_q); op_b = MOP_W'(c14_q); end
			endcase
		end else if (state_q == GEN_MUL) begin
			unique case (idx_q)
				4'd0: begin op_a = u_q[0]; op_b = u_q[0]; end
				4'd1: begin op_a = u_q[0]; op_b = u_q[1]; end
				4'd2: begin op_a = u_q[0]; op_b = u_q[2]; end
				4'd3: begin op_a = u_q[1]; op_b = u_q[1]; end
				4'd4: begin op_a = u_q[1]; op_b = u_q[2]; end
				4'd5: begin op_a = u_q[2]; op_b = u_q[2]; end
				4'd6: begin op_a = signed'(MOP_W'(s_q)); op_b = u_q[0]; end
				4'd7: begin op_a = signed'(MOP_W'(s_q)); op_b = u_q[1]; end
				4'd8: begin op_a = signed'(MOP_W'(s_q)); op_b = u_q[2]; end
				default: begin op_a = MOP_W'(pp_q[pidx]); op_b = k_op; end
			endcase
		end
	end

	// sequencer control and matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_IDLE;
			idx_q   <= '0;
			ph_q    <= 1'b0;
			go_q    <= 1'b0;
			for (int i = 0; i < 9; i++)
				mat_q[i] <= (i % 4 == 0) ? q14_t'(Q14_ONE) : '0;
		end else begin
			state_q <= state_d;
			if (start_q) begin
				idx_q <= '0;
				ph_q  <= 1'b0;
				go_q  <= 1'b0;
			end else begin
				unique case (state_q)
					GEN_INIT: begin
						if (axis_zero) begin
							for (int i = 0; i < 9; i++)
								mat_q[i] <= (i % 4 != 0) ? '0 :
									(cos_q <= -COS_WIDTH'(Q14_ONE)) ? -q14_t'(Q14_ONE) :
									q14_t'(Q14_ONE);
						end
					end
					GEN_SQ, GEN_MUL: begin
						ph_q <= ~ph_q;
						if (ph_q)
							idx_q <= (state_d != state_q) ? 4'd0 : idx_q + 4'd1;
					end
					GEN_SQRT_L, GEN_SQRT_S: begin
						if (!go_q)
							go_q <= 1'b1;
						else if (!sq_busy)
							go_q <= 1'b0;
					end
					GEN_DIV: begin
						if (!go_q) begin
							go_q <= 1'b1;
						end else if (!dv_busy) begin
							go_q  <= 1'b0;
							idx_q <= (idx_q == 4'd2) ? 4'd0 : idx_q + 4'd1;
						end
					end
					GEN_ASM: begin
						mat_q[0] <= to_q14(add2(pp_q[0], c_q30));
						mat_q[1] <= to_q14(add2(pp_q[1], su_q[2]));
						mat_q[2] <= to_q14(sub2(pp_q[2], su_q[1]));
						mat_q[3] <= to_q14(sub2(pp_q[1], su_q[2]));
						mat_q[4] <= to_q14(add2(pp_q[3], c_q30));
						mat_q[5] <= to_q14(add2(pp_q[4], su_q[0]));
						mat_q[6] <= to_q14(add2(pp_q[2], su_q[1]));
						mat_q[7] <= to_q14(sub2(pp_q[4], su_q[0]));
						mat_q[8] <= to_q14(add2(pp_q[5], c_q30));
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == GEN_INIT) begin
			for (int i = 0; i < 3; i++)
				ax_q[i] <= ax_sh[i];
			c14_q <= c14;
			n2_q  <= '0;
		end
		if ((state_q == GEN_SQ || state_q == GEN_MUL) && !ph_q)
			prod_q <= op_a * op_b;
		if (state_q == GEN_SQ && ph_q) begin
			if (idx_q == 4'd3)
				csq_q <= prod_q[28:0];
			else
				n2_q <= n2_q + prod_q[47:0];
		end
		if (state_q == GEN_MUL && ph_q) begin
			if (idx_q < 4'd6)
				pp_q[idx_q[2:0]] <= m30;
			else if (idx_q < 4'd9)
				su_q[2'(idx_q - 4'd6)] <= m30;
			else
				pp_q[pidx] <= m30;
		end
		if (state_q == GEN_SQRT_L && go_q && !sq_busy)
			len_q <= sq_root;
		if (state_q == GEN_SQRT_S && go_q && !sq_busy)
			s_q <= sq_root;
		if (state_q == GEN_DIV && go_q && !dv_busy)
			u_q[idx_q[1:0]] <= dv_ax[AX_W-1] ? -dv_qx : dv_qx;
	end

	aapr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	aapr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dividend),
		.divisor  (len_q),
		.busy     (dv_busy),
		.quotient (dv_quo)
	);

	assign matrix = mat_q;

endmodule

/* rtl/aapr_lane.sv */
module aapr_lane import aapr_pkg::*; (
	input  logic                          clk,
	input  pipe_ctl_t                     ctl,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  q14_t                          m0,
	input  q14_t                          m1,
	input  q14_t                          m2,
	output logic signed [COORD_WIDTH-1:0] val,
	output logic                          clip
);

	localparam logic signed [SUM_W-1:0] HI_LIM = (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] LO_LIM = -HI_LIM - SUM_W'(1);

	logic signed [PROD_W-1:0]      prod_s1 [3];
	logic signed [COORD_WIDTH-1:0] val_s2;
	logic                          clip_s2;
	logic signed [SUM_W-1:0]       sum;
	logic signed [SUM_W-1:0]       rnd;

	// round half up back to Q16.16
	assign sum = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2]) + SUM_W'(8192);
	assign rnd = sum >>> 14;

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			prod_s1[0] <= PROD_W'(px) * PROD_W'(m0);
			prod_s1[1] <= PROD_W'(py) * PROD_W'(m1);
			prod_s1[2] <= PROD_W'(pz) * PROD_W'(m2);
		end
		if (ctl.en2) begin
			if (rnd > HI_LIM) begin
				val_s2  <= COORD_WIDTH'(HI_LIM);
				clip_s2 <= 1'b1;
			end else if (rnd < LO_LIM) begin
				val_s2  <= COORD_WIDTH'(LO_LIM);
				clip_s2 <= 1'b1;
			end else begin
				val_s2  <= COORD_WIDTH'(rnd);
				clip_s2 <= 1'b0;
			end
		end
	end

	assign val  = val_s2;
	assign clip = clip_s2;

endmodule

/* rtl/axis_angle_point_rotator.sv */
// Axis-angle point rotator.
//
// Configuration: write axis_x/y/z (index 0..2) and cos_angle (index 3, Q2.14)
// through cfg_we/cfg_index/cfg_wdata while no points are in flight. Every write
// starts a matrix rebuild: axis normalization, two bit-serial square roots and
// three bit-serial divisions, then fifteen steps of a shared multiplier. The
// rebuild holds in_stall high until the new matrix is registered. A zero axis gives
// the identity (negated when cos_angle is at or below -1).
//
// Points: one Q16.16 point transfers on in_valid with in_stall low. Three
// row lanes form their dot products and a merge stage registers rot_x/y/z and
// the clipped flag. A point passes the lane product and saturation registers and
// then the merge register, which raises out_valid; one point per cycle is taken
// while in_stall is low, set by the single-stage lane multipliers.
// When the receiver holds out_stall, the output register holds its transfer and
// the two lane stages fill before in_stall rises.
//
// Reset: axis cleared, cos_angle one, identity matrix, pipeline empty.
module axis_angle_point_rotator import aapr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] rot_x,
	output logic signed [COORD_WIDTH-1:0] rot_y,
	output logic signed [COORD_WIDTH-1:0] rot_z,
	output logic                          clipped
);

	mat_t      matrix;
	logic      gen_busy;
	pipe_ctl_t ctl;
	logic      en_out;
	logic      accept;
	logic      v_s1, v_s2, out_valid_q;

	logic signed [COORD_WIDTH-1:0] lane_val [3];
	logic                          lane_clip [3];
	logic signed [COORD_WIDTH-1:0] rot_q [3];
	logic                          clipped_q;

	aapr_mgen u_mgen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.busy      (gen_busy),
		.matrix    (matrix)
	);

	// advance each stage when the one after it is empty or moving
	assign en_out   = !out_valid_q || !out_stall;
	assign ctl.en2  = !v_s2 || en_out;
	assign ctl.en1  = !v_s1 || ctl.en2;
	assign in_stall = gen_busy || !ctl.en1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.en1) v_s1 <= accept;
			if (ctl.en2) v_s2 <= v_s1;
			if (en_out)  out_valid_q <= v_s2;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_lane
		aapr_lane u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.px   (point_x),
			.py   (point_y),
			.pz   (point_z),
			.m0   (matrix[3*r]),
			.m1   (matrix[3*r+1]),
			.m2   (matrix[3*r+2]),
			.val  (lane_val[r]),
			.clip (lane_clip[r])
		);
	end

	// merge: gather the three rows and fold the saturation flags
	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			for (int r = 0; r < 3; r++)
				rot_q[r] <= lane_val[r];
			clipped_q <= lane_clip[0] | lane_clip[1] | lane_clip[2];
		end
	end

	assign out_valid = out_valid_q;
	assign rot_x     = rot_q[0];
	assign rot_y     = rot_q[1];
	assign rot_z     = rot_q[2];
	assign clipped   = clipped_q;

endmodule

/* rtl/aapr_checker.sv */
module aapr_sva import aapr_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [COORD_WIDTH-1:0] rot_x,
	input logic signed [COORD_WIDTH-1:0] rot_y,
	input logic signed [COORD_WIDTH-1:0] rot_z,
	input logic                          clipped
);

	localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
			&& $stable(clipped))
		else $error("output changed while stalled");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken during matrix rebuild");

	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> rot_x == MAXV || rot_x == MINV || rot_y == MAXV
			|| rot_y == MINV || rot_z == MAXV || rot_z == MINV)
		else $error("clipped set without a saturated component");

endmodule

bind axis_angle_point_rotator aapr_sva u_aapr_sva (.*);
